@@ rtl/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

    localparam int ELEM_W     = 16;
    localparam int NUM_ELEM   = 9;
    localparam int VAL_W      = 18;
    localparam int MAG_W      = 17;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int NRM_W      = 35;
    localparam int NORM_SHIFT = 28;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 34;
    localparam int DEN_W      = ROOT_W + 1;
    localparam int DIV_W      = 48;
    localparam int QUO_W      = 16;
    localparam int NUM_COMP   = 4;
    localparam int ONE_Q14    = 16384;

    localparam int LAT_FRONT  = 4;
    localparam int LAT_SQRT   = ROOT_W;
    localparam int LAT_DIV    = QUO_W + 1;
    localparam int LATENCY    = LAT_FRONT + LAT_SQRT + LAT_DIV + 1;

    // Matrix element order: c0r0 c0r1 c0r2 c1r0 c1r1 c1r2 c2r0 c2r1 c2r2
    typedef logic [NUM_ELEM-1:0][ELEM_W-1:0] rmq_mat_t;

    // Component order: x y z w
    typedef struct packed {
        logic                bad;
        logic [NUM_COMP-1:0] neg;
    } rmq_flags_t;

    typedef struct packed {
        rmq_flags_t                          flags;
        logic [NUM_COMP-1:0][MAG_W-1:0]      mag;
    } rmq_item_t;

    typedef logic [NUM_COMP-1:0][QUO_W-1:0] rmq_quo_t;

endpackage

@@ rtl/rmq_front.sv @@
// Front end: pivot selection, scaled quaternion, squares and squared norm.
module rmq_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rmq_pkg::rmq_mat_t     in_mat,
    output logic                  out_valid,
    output rmq_pkg::rmq_item_t    out_item,
    output logic [rmq_pkg::NRM_W-1:0] out_nrm
);

    localparam logic signed [rmq_pkg::VAL_W-1:0] ONE =
        rmq_pkg::VAL_W'(rmq_pkg::ONE_Q14);

    logic                     s1_valid_reg;
    rmq_pkg::rmq_mat_t        mat_reg;
    logic                     s2_valid_reg;
    rmq_pkg::rmq_item_t       s2_item_reg;
    rmq_pkg::rmq_item_t       s2_item_next;
    logic                     s3_valid_reg;
    rmq_pkg::rmq_item_t       s3_item_reg;
    logic [rmq_pkg::SQ_W-1:0] sq_reg [rmq_pkg::NUM_COMP];
    logic [rmq_pkg::SQ_W-1:0] sq_next [rmq_pkg::NUM_COMP];
    logic                     s4_valid_reg;
    rmq_pkg::rmq_item_t       s4_item_reg;
    logic [rmq_pkg::NRM_W-1:0] nrm_reg;
    logic [rmq_pkg::NRM_W-1:0] nrm_next;

    logic signed [rmq_pkg::VAL_W-1:0] a [rmq_pkg::NUM_ELEM];
    logic signed [rmq_pkg::VAL_W-1:0] v [rmq_pkg::NUM_COMP];
    logic signed [rmq_pkg::VAL_W-1:0] trace;
    logic signed [rmq_pkg::VAL_W-1:0] rad;

    always_comb
    begin
        for (int i = 0; i < rmq_pkg::NUM_ELEM; i++)
        begin
            a[i] = rmq_pkg::VAL_W'(signed'(mat_reg[i]));
        end
        trace = a[0] + a[4] + a[8];
        if (trace > 0)
        begin
            rad  = ONE + trace;
            v[0] = a[5] - a[7];
            v[1] = a[6] - a[2];
            v[2] = a[1] - a[3];
            v[3] = rad;
        end
        else if (a[0] > a[4] && a[0] > a[8])
        begin
            rad  = ONE + a[0] - a[4] - a[8];
            v[0] = rad;
            v[1] = a[1] + a[3];
            v[2] = a[2] + a[6];
            v[3] = a[5] - a[7];
        end
        else if (a[4] > a[8])
        begin
            rad  = ONE + a[4] - a[0] - a[8];
            v[0] = a[1] + a[3];
            v[1] = rad;
            v[2] = a[5] + a[7];
            v[3] = a[6] - a[2];
        end
        else
        begin
            rad  = ONE + a[8] - a[0] - a[4];
            v[0] = a[2] + a[6];
            v[1] = a[5] + a[7];
            v[2] = rad;
            v[3] = a[1] - a[3];
        end
        s2_item_next.flags.bad = (rad <= 0);
        for (int i = 0; i < rmq_pkg::NUM_COMP; i++)
        begin
            s2_item_next.flags.neg[i] = v[i] < 0;
            s2_item_next.mag[i] = (v[i] < 0) ? rmq_pkg::MAG_W'(-v[i])
                                             : rmq_pkg::MAG_W'(v[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < rmq_pkg::NUM_COMP; i++)
        begin
            sq_next[i] = rmq_pkg::SQ_W'(s2_item_reg.mag[i]) *
                         rmq_pkg::SQ_W'(s2_item_reg.mag[i]);
        end
        nrm_next = rmq_pkg::NRM_W'(sq_reg[0]) + rmq_pkg::NRM_W'(sq_reg[1]) +
                   rmq_pkg::NRM_W'(sq_reg[2]) + rmq_pkg::NRM_W'(sq_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mat_reg     <= in_mat;
        s2_item_reg <= s2_item_next;
        s3_item_reg <= s2_item_reg;
        sq_reg      <= sq_next;
        s4_item_reg <= s3_item_reg;
        nrm_reg     <= nrm_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;
    assign out_nrm   = nrm_reg;

endmodule

@@ rtl/rmq_sqrt.sv @@
// Pipelined integer square root of the norm scaled by 2^28, one root bit per stage.
module rmq_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  rmq_pkg::rmq_item_t         in_item,
    input  logic [rmq_pkg::NRM_W-1:0]  in_nrm,
    output logic                       out_valid,
    output rmq_pkg::rmq_item_t         out_item,
    output logic [rmq_pkg::ROOT_W-1:0] out_root
);

    localparam int STAGES = rmq_pkg::ROOT_W;
    localparam int RAD_W  = 2 * rmq_pkg::ROOT_W;

    logic                       valid_reg [STAGES];
    rmq_pkg::rmq_item_t         item_reg  [STAGES];
    logic [rmq_pkg::NRM_W-1:0]  nrm_reg   [STAGES];
    logic [rmq_pkg::REM_W-1:0]  rem_reg   [STAGES];
    logic [rmq_pkg::ROOT_W-1:0] root_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int J = STAGES - 1 - k;

        logic                       valid_src;
        rmq_pkg::rmq_item_t         item_src;
        logic [rmq_pkg::NRM_W-1:0]  nrm_src;
        logic [rmq_pkg::REM_W-1:0]  rem_src;
        logic [rmq_pkg::ROOT_W-1:0] root_src;
        logic [RAD_W-1:0]           rad_full;
        logic [rmq_pkg::REM_W+1:0]  acc;
        logic [rmq_pkg::REM_W+1:0]  trial;
        logic [rmq_pkg::REM_W-1:0]  rem_next;
        logic [rmq_pkg::ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign valid_src = in_valid;
            assign item_src  = in_item;
            assign nrm_src   = in_nrm;
            assign rem_src   = '0;
            assign root_src  = '0;
        end
        else
        begin : g_next
            assign valid_src = valid_reg[k-1];
            assign item_src  = item_reg[k-1];
            assign nrm_src   = nrm_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign root_src  = root_reg[k-1];
        end

        always_comb
        begin
            rad_full = {1'b0, nrm_src, rmq_pkg::NORM_SHIFT'(0)};
            acc      = {rem_src, rad_full[2*J+1 -: 2]};
            trial    = (rmq_pkg::REM_W+2)'({root_src, 2'b01});
            if (acc >= trial)
            begin
                rem_next  = rmq_pkg::REM_W'(acc - trial);
                root_next = {root_src[rmq_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rmq_pkg::REM_W'(acc);
                root_next = {root_src[rmq_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            item_reg[k] <= item_src;
            nrm_reg[k]  <= nrm_src;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];
    assign out_root  = root_reg[STAGES-1];

endmodule

@@ rtl/rmq_div.sv @@
// Pipelined rounded division of each component by the norm, four lanes, one bit per stage.
module rmq_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  rmq_pkg::rmq_item_t         in_item,
    input  logic [rmq_pkg::ROOT_W-1:0] in_root,
    output logic                       out_valid,
    output rmq_pkg::rmq_flags_t        out_flags,
    output rmq_pkg::rmq_quo_t          out_quo
);

    localparam int STAGES = rmq_pkg::QUO_W;
    localparam int LANES  = rmq_pkg::NUM_COMP;

    logic                       prep_valid_reg;
    rmq_pkg::rmq_flags_t        prep_flags_reg;
    logic [rmq_pkg::DEN_W-1:0]  prep_den_reg;
    logic [rmq_pkg::DIV_W-1:0]  prep_num_reg [LANES];
    logic [rmq_pkg::DIV_W-1:0]  prep_num_next [LANES];

    logic                       valid_reg [STAGES];
    rmq_pkg::rmq_flags_t        flags_reg [STAGES];
    logic [rmq_pkg::DEN_W-1:0]  den_reg   [STAGES];
    logic [rmq_pkg::DIV_W-1:0]  rem_reg   [STAGES][LANES];
    logic [rmq_pkg::QUO_W-1:0]  quo_reg   [STAGES][LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            prep_num_next[l] =
                (rmq_pkg::DIV_W'(in_item.mag[l]) << (rmq_pkg::NORM_SHIFT + 1)) +
                rmq_pkg::DIV_W'(in_root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prep_flags_reg <= in_item.flags;
        prep_den_reg   <= {in_root, 1'b0};
        prep_num_reg   <= prep_num_next;
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int BIT = STAGES - 1 - k;

        logic                       valid_src;
        rmq_pkg::rmq_flags_t        flags_src;
        logic [rmq_pkg::DEN_W-1:0]  den_src;
        logic [rmq_pkg::DIV_W-1:0]  rem_src  [LANES];
        logic [rmq_pkg::QUO_W-1:0]  quo_src  [LANES];
        logic [rmq_pkg::DIV_W-1:0]  sub;
        logic [rmq_pkg::DIV_W-1:0]  rem_next [LANES];
        logic [rmq_pkg::QUO_W-1:0]  quo_next [LANES];

        if (k == 0)
        begin : g_first
            assign valid_src = prep_valid_reg;
            assign flags_src = prep_flags_reg;
            assign den_src   = prep_den_reg;
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign rem_src[l] = prep_num_reg[l];
                assign quo_src[l] = '0;
            end
        end
        else
        begin : g_next
            assign valid_src = valid_reg[k-1];
            assign flags_src = flags_reg[k-1];
            assign den_src   = den_reg[k-1];
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign rem_src[l] = rem_reg[k-1][l];
                assign quo_src[l] = quo_reg[k-1][l];
            end
        end

        always_comb
        begin
            sub = rmq_pkg::DIV_W'(den_src) << BIT;
            for (int l = 0; l < LANES; l++)
            begin
                rem_next[l] = rem_src[l];
                quo_next[l] = quo_src[l];
                if (rem_src[l] >= sub)
                begin
                    rem_next[l]      = rem_src[l] - sub;
                    quo_next[l][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            flags_reg[k] <= flags_src;
            den_reg[k]   <= den_src;
            rem_reg[k]   <= rem_next;
            quo_reg[k]   <= quo_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_flags = flags_reg[STAGES-1];
    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign out_quo[l] = quo_reg[STAGES-1][l];
    end

endmodule

@@ rtl/rotation_matrix_to_quaternion.sv @@
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
// Channel   Direction  Handshake             Payload
// command   in         start (busy is low)   elem_c0_r0 .. elem_c2_r2
// result    out        done (one cycle)      quat_x quat_y quat_z quat_w not_rotation
//
// One matrix enters per cycle.
// The square root has 32 stages and the divider 16, one bit per stage.
// busy is held low: the pipeline never stalls and the receiver cannot stall.
// rst_n clears the valid bits only; data registers are not reset.
module rotation_matrix_to_quaternion (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] elem_c0_r0,
    input  logic signed [15:0] elem_c0_r1,
    input  logic signed [15:0] elem_c0_r2,
    input  logic signed [15:0] elem_c1_r0,
    input  logic signed [15:0] elem_c1_r1,
    input  logic signed [15:0] elem_c1_r2,
    input  logic signed [15:0] elem_c2_r0,
    input  logic signed [15:0] elem_c2_r1,
    input  logic signed [15:0] elem_c2_r2,
    output logic               done,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic               not_rotation
);

    localparam logic [rmq_pkg::QUO_W-1:0] ONE_Q = rmq_pkg::QUO_W'(rmq_pkg::ONE_Q14);

    rmq_pkg::rmq_mat_t          in_mat;
    logic                       front_valid;
    rmq_pkg::rmq_item_t         front_item;
    logic [rmq_pkg::NRM_W-1:0]  front_nrm;
    logic                       sqrt_valid;
    rmq_pkg::rmq_item_t         sqrt_item;
    logic [rmq_pkg::ROOT_W-1:0] sqrt_root;
    logic                       div_valid;
    rmq_pkg::rmq_flags_t        div_flags;
    rmq_pkg::rmq_quo_t          div_quo;

    logic                       done_reg;
    logic [rmq_pkg::ELEM_W-1:0] quat_reg  [rmq_pkg::NUM_COMP];
    logic [rmq_pkg::ELEM_W-1:0] quat_next [rmq_pkg::NUM_COMP];
    logic                       bad_reg;
    logic [rmq_pkg::QUO_W-1:0]  clip      [rmq_pkg::NUM_COMP];

    assign busy = 1'b0;

    assign in_mat = {elem_c2_r2, elem_c2_r1, elem_c2_r0,
                     elem_c1_r2, elem_c1_r1, elem_c1_r0,
                     elem_c0_r2, elem_c0_r1, elem_c0_r0};

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_mat    (in_mat),
        .out_valid (front_valid),
        .out_item  (front_item),
        .out_nrm   (front_nrm)
    );

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .in_nrm    (front_nrm),
        .out_valid (sqrt_valid),
        .out_item  (sqrt_item),
        .out_root  (sqrt_root)
    );

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .in_item   (sqrt_item),
        .in_root   (sqrt_root),
        .out_valid (div_valid),
        .out_flags (div_flags),
        .out_quo   (div_quo)
    );

    always_comb
    begin
        for (int i = 0; i < rmq_pkg::NUM_COMP; i++)
        begin
            clip[i] = (div_quo[i] > ONE_Q) ? ONE_Q : div_quo[i];
            if (div_flags.bad)
            begin
                quat_next[i] = '0;
            end
            else if (div_flags.neg[i])
            begin
                quat_next[i] = rmq_pkg::ELEM_W'(-clip[i]);
            end
            else
            begin
                quat_next[i] = rmq_pkg::ELEM_W'(clip[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= quat_next;
        bad_reg  <= div_flags.bad;
    end

    assign done         = done_reg;
    assign quat_x       = quat_reg[0];
    assign quat_y       = quat_reg[1];
    assign quat_z       = quat_reg[2];
    assign quat_w       = quat_reg[3];
    assign not_rotation = bad_reg;

    a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        done && not_rotation |-> quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w == 0)
        else $error("non-rotation result not zeroed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> quat_x >= -16384 && quat_x <= 16384 && quat_y >= -16384 &&
                 quat_y <= 16384 && quat_z >= -16384 && quat_z <= 16384 &&
                 quat_w >= -16384 && quat_w <= 16384)
        else $error("quaternion component out of range");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !not_rotation |-> (quat_x | quat_y | quat_z | quat_w) != 0)
        else $error("valid rotation gave zero quaternion");

endmodule

@@ tb/rmq_checker.sv @@
// Checker: predicts the quaternion for each accepted matrix and compares results.
`timescale 1ns / 100ps
module rmq_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] elem_c0_r0,
    input  logic signed [15:0] elem_c0_r1,
    input  logic signed [15:0] elem_c0_r2,
    input  logic signed [15:0] elem_c1_r0,
    input  logic signed [15:0] elem_c1_r1,
    input  logic signed [15:0] elem_c1_r2,
    input  logic signed [15:0] elem_c2_r0,
    input  logic signed [15:0] elem_c2_r1,
    input  logic signed [15:0] elem_c2_r2,
    input  logic               done,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic               not_rotation,
    output int                 fail_count,
    output int                 pending,
    output int                 bad_seen
);

    typedef struct {
        logic signed [15:0] x, y, z, w;
        logic               bad;
    } quat_t;

    quat_t quat_fifo[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] scale_comp(longint v, longint unsigned len);
        longint unsigned m, q;
        m = (v < 0) ? -v : v;
        q = ((m << 29) + len) / (len << 1);
        if (q > 16384) q = 16384;
        return (v < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic quat_t predict_quat(longint a00, longint a01, longint a02,
                                           longint a10, longint a11, longint a12,
                                           longint a20, longint a21, longint a22);
        longint tr, rad;
        longint q[4];
        longint unsigned n, len;
        quat_t r;
        tr = a00 + a11 + a22;
        if (tr > 0)
        begin
            rad = 16384 + tr;
            q[3] = rad; q[0] = a12 - a21; q[1] = a20 - a02; q[2] = a01 - a10;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            rad = 16384 + a00 - a11 - a22;
            q[0] = rad; q[3] = a12 - a21; q[1] = a01 + a10; q[2] = a02 + a20;
        end
        else if (a11 > a22)
        begin
            rad = 16384 + a11 - a00 - a22;
            q[1] = rad; q[3] = a20 - a02; q[0] = a01 + a10; q[2] = a12 + a21;
        end
        else
        begin
            rad = 16384 + a22 - a00 - a11;
            q[2] = rad; q[3] = a01 - a10; q[0] = a02 + a20; q[1] = a12 + a21;
        end
        if (rad <= 0)
        begin
            r.x = '0; r.y = '0; r.z = '0; r.w = '0; r.bad = 1'b1;
            return r;
        end
        n = 0;
        for (int i = 0; i < 4; i++) n += q[i] * q[i];
        len = int_sqrt(n << 28);
        r.x = scale_comp(q[0], len);
        r.y = scale_comp(q[1], len);
        r.z = scale_comp(q[2], len);
        r.w = scale_comp(q[3], len);
        r.bad = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        bad_seen = 0;
    end

    assign pending = quat_fifo.size();

    always @(posedge clk)
    begin
        quat_t e;
        if (rst_n && start && !busy)
            quat_fifo.push_back(predict_quat(elem_c0_r0, elem_c0_r1, elem_c0_r2,
                                             elem_c1_r0, elem_c1_r1, elem_c1_r2,
                                             elem_c2_r0, elem_c2_r1, elem_c2_r2));
        if (rst_n && done)
        begin
            if (quat_fifo.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = quat_fifo.pop_front();
                if (e.bad) bad_seen++;
                if (quat_x !== e.x) report_mismatch("quat_x", quat_x, e.x);
                if (quat_y !== e.y) report_mismatch("quat_y", quat_y, e.y);
                if (quat_z !== e.z) report_mismatch("quat_z", quat_z, e.z);
                if (quat_w !== e.w) report_mismatch("quat_w", quat_w, e.w);
                if (not_rotation !== e.bad)
                    report_mismatch("not_rotation", not_rotation, e.bad);
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: drives matrices into the converter and gives the verdict.
`timescale 1ns / 100ps
module tb_top;

    logic               clk, rst_n, start, busy, done, not_rotation;
    logic signed [15:0] e[9];
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    int                 fail_count, pending, bad_seen, cycles, sent, idle_pct;

    rotation_matrix_to_quaternion u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .elem_c0_r0(e[0]), .elem_c0_r1(e[1]), .elem_c0_r2(e[2]),
        .elem_c1_r0(e[3]), .elem_c1_r1(e[4]), .elem_c1_r2(e[5]),
        .elem_c2_r0(e[6]), .elem_c2_r1(e[7]), .elem_c2_r2(e[8]),
        .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .quat_w(quat_w), .not_rotation(not_rotation)
    );

    rmq_checker u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .elem_c0_r0(e[0]), .elem_c0_r1(e[1]), .elem_c0_r2(e[2]),
        .elem_c1_r0(e[3]), .elem_c1_r1(e[4]), .elem_c1_r2(e[5]),
        .elem_c2_r0(e[6]), .elem_c2_r1(e[7]), .elem_c2_r2(e[8]),
        .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .quat_w(quat_w), .not_rotation(not_rotation),
        .fail_count(fail_count), .pending(pending), .bad_seen(bad_seen)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] rand_elem(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(32768)) - 16384);
            default: return 16'($signed($urandom_range(1000)) - 500);
        endcase
    endfunction

    // send one matrix; hold it until the transfer edge
    task automatic send_matrix(logic signed [15:0] m[9]);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        for (int i = 0; i < 9; i++) e[i] <= m[i];
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
    endtask

    task automatic send_rotation(int axis, int c, int s);
        logic signed [15:0] m[9];
        for (int i = 0; i < 9; i++) m[i] = '0;
        m[axis * 4] = 16'sd16384;
        case (axis)
            0: begin m[4] = 16'(c); m[8] = 16'(c); m[5] = 16'(s); m[7] = 16'(-s); end
            1: begin m[0] = 16'(c); m[8] = 16'(c); m[6] = 16'(s); m[2] = 16'(-s); end
            default: begin m[0] = 16'(c); m[4] = 16'(c); m[1] = 16'(s); m[3] = 16'(-s); end
        endcase
        for (int i = 0; i < 9; i++)
            if (m[i] > 16384) m[i] = 16'sd16384;
        send_matrix(m);
    endtask

    initial
    begin
        logic signed [15:0] m[9];
        int ang;
        start = 0;
        for (int i = 0; i < 9; i++) e[i] = '0;
        rst_n = 0;
        sent = 0;
        idle_pct = 18;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
        send_matrix(m);
        send_rotation(0, -16384, 0);
        send_rotation(1, -16384, 0);
        send_rotation(2, -16384, 0);
        send_rotation(0, 0, 16384);
        send_rotation(1, 0, -16384);
        send_rotation(2, 11585, 11585);
        for (int i = 0; i < 9; i++) m[i] = '0;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? -16'sd16384 : 16'sd0;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = 16'sh7fff;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = 16'sh8000;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 16'sh8000 : 16'sh7fff;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 16'sd5000 : 16'sd100;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? -16'sd5000 : 16'sd300;
        m[0] = -16'sd4000; m[4] = -16'sd4000;
        send_matrix(m);
        m[8] = -16'sd4000;
        send_matrix(m);

        for (int n = 0; n < 750; n++)
        begin
            if (n == 250) idle_pct = 55;
            if (n == 500) idle_pct = 0;
            if ($urandom_range(9) < 6)
            begin
                ang = $urandom_range(32768);
                send_rotation($urandom_range(2), ang - 16384,
                              ($urandom_range(1) ? 1 : -1) * $urandom_range(16384));
            end
            else
            begin
                for (int i = 0; i < 9; i++) m[i] = rand_elem($urandom_range(2));
                send_matrix(m);
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d matrices (rotations, edge patterns, random words);", sent);
        $display("%0d of them were flagged as not a rotation.", bad_seen);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
